// File: hw/rtl/tcw_pkg.sv
package tcw_pkg;

   // default screen geometry
   localparam int unsigned DEF_COLUMNS = 80;
   localparam int unsigned DEF_ROWS    = 25;

   localparam int unsigned KIND_W = 2;
   localparam int unsigned CHAR_W = 8;
   localparam int unsigned ATTR_W = 8;
   localparam int unsigned CELL_W = ATTR_W + CHAR_W;

   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0f;

   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_RETURN  = 8'd13;

   // item kinds carried on tuser
   localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

   // microprogram steps
   typedef enum logic [3:0] {
      S_RCLR,
      S_IDLE,
      S_CHR,
      S_NL,
      S_CR,
      S_EMIT,
      S_RD0,
      S_RD1,
      S_CLR0,
      S_CLR1,
      S_SC0,
      S_SC1,
      S_SC2,
      S_SC3,
      S_REDISP
   } step_type;

   typedef enum logic [1:0] {
      JMP_GOTO,
      JMP_LOOP,
      JMP_ACCEPT,
      JMP_DISPATCH
   } jump_type;

   typedef enum logic {
      LIM_COPY,
      LIM_END
   } lim_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_ZERO,
      WR_CHAR
   } wr_type;

   typedef enum logic [1:0] {
      ADDR_HOLD,
      ADDR_ZERO,
      ADDR_INC
   } addr_op_type;

   typedef enum logic [2:0] {
      CUR_HOLD,
      CUR_INC,
      CUR_NL,
      CUR_CR,
      CUR_HOME,
      CUR_SCROLL
   } cur_type;

   typedef struct packed {
      jump_type    jump;
      step_type    nxt;
      lim_type     lim;
      wr_type      wr;
      addr_op_type addr_op;
      cur_type     cur;
      logic        copy;
      logic        rd_item;
      logic        emit;
      logic        emit_rd;
   } ctrl_word_type;

   typedef struct packed {
      logic              full;
      logic              addr_last;
      logic [KIND_W-1:0] kind;
      logic [CHAR_W-1:0] code;
   } status_type;

   // control store
   function automatic ctrl_word_type microcode(input step_type s);
      ctrl_word_type cw;
      cw = '{jump: JMP_GOTO, nxt: S_IDLE, lim: LIM_END, wr: WR_NONE, addr_op: ADDR_HOLD,
             cur: CUR_HOLD, copy: 1'b0, rd_item: 1'b0, emit: 1'b0, emit_rd: 1'b0};
      case (s)
         S_RCLR: begin
            cw.jump    = JMP_LOOP;
            cw.wr      = WR_ZERO;
            cw.addr_op = ADDR_INC;
         end
         S_IDLE: begin
            cw.jump = JMP_ACCEPT;
         end
         S_CHR: begin
            cw.wr   = WR_CHAR;
            cw.cur  = CUR_INC;
            cw.emit = 1'b1;
         end
         S_NL: begin
            cw.cur  = CUR_NL;
            cw.emit = 1'b1;
         end
         S_CR: begin
            cw.cur  = CUR_CR;
            cw.emit = 1'b1;
         end
         S_EMIT: begin
            cw.emit = 1'b1;
         end
         S_RD0: begin
            cw.rd_item = 1'b1;
            cw.nxt     = S_RD1;
         end
         S_RD1: begin
            cw.emit    = 1'b1;
            cw.emit_rd = 1'b1;
         end
         S_CLR0: begin
            cw.addr_op = ADDR_ZERO;
            cw.cur     = CUR_HOME;
            cw.nxt     = S_CLR1;
         end
         S_CLR1: begin
            cw.jump    = JMP_LOOP;
            cw.wr      = WR_ZERO;
            cw.addr_op = ADDR_INC;
            cw.nxt     = S_EMIT;
         end
         S_SC0: begin
            cw.addr_op = ADDR_ZERO;
            cw.cur     = CUR_SCROLL;
            cw.nxt     = S_SC1;
         end
         S_SC1: begin
            cw.jump    = JMP_LOOP;
            cw.lim     = LIM_COPY;
            cw.copy    = 1'b1;
            cw.addr_op = ADDR_INC;
            cw.nxt     = S_SC2;
         end
         S_SC2: begin
            cw.nxt = S_SC3;
         end
         S_SC3: begin
            cw.jump    = JMP_LOOP;
            cw.wr      = WR_ZERO;
            cw.addr_op = ADDR_INC;
            cw.nxt     = S_REDISP;
         end
         S_REDISP: begin
            cw.jump = JMP_DISPATCH;
         end
         default: begin
            cw.nxt = S_IDLE;
         end
      endcase
      return cw;
   endfunction

   // entry point of the routine for an item
   function automatic step_type dispatch(input logic [KIND_W-1:0] kind,
                                         input logic [CHAR_W-1:0] code,
                                         input logic full);
      step_type s;
      s = S_EMIT;
      case (kind)
         KIND_PUT: begin
            if (full) begin
               s = S_SC0;
            end else if (code == CHAR_NEWLINE) begin
               s = S_NL;
            end else if (code == CHAR_RETURN) begin
               s = S_CR;
            end else begin
               s = S_CHR;
            end
         end
         KIND_CLEAR: begin
            s = S_CLR0;
         end
         KIND_READ: begin
            s = S_RD0;
         end
         default: begin
            s = S_EMIT;
         end
      endcase
      return s;
   endfunction

endpackage

// File: hw/rtl/tcw_screen_ram.sv
module tcw_screen_ram #(
   parameter int unsigned DEPTH = 2000,
   parameter int unsigned AW    = 11,
   parameter int unsigned DW    = 16
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic          re,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: hw/rtl/tcw_sequencer.sv
module tcw_sequencer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  hold,
   input  logic                  req_valid,
   input  tcw_pkg::status_type   status,
   output tcw_pkg::ctrl_word_type cw,
   output logic                  req_ready
);

   import tcw_pkg::*;

   step_type pc_ff;
   step_type pc_in;

   // next step
   always_comb begin
      pc_in = pc_ff;
      if (!hold) begin
         case (cw.jump)
            JMP_GOTO: begin
               pc_in = cw.nxt;
            end
            JMP_LOOP: begin
               pc_in = status.addr_last ? cw.nxt : pc_ff;
            end
            JMP_ACCEPT: begin
               pc_in = req_valid ? dispatch(status.kind, status.code, status.full) : pc_ff;
            end
            JMP_DISPATCH: begin
               pc_in = dispatch(status.kind, status.code, status.full);
            end
            default: begin
               pc_in = S_IDLE;
            end
         endcase
      end
   end

   // control word out of the store
   always_comb begin
      cw        = microcode(pc_ff);
      req_ready = (cw.jump == JMP_ACCEPT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= S_RCLR;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// File: hw/rtl/tcw_datapath.sv
module tcw_datapath #(
   parameter int unsigned COLUMNS = 80,
   parameter int unsigned ROWS    = 25,
   parameter int unsigned CUR_W   = 11
) (
   input  logic                         clock,
   input  logic                         reset,
   input  tcw_pkg::ctrl_word_type       cw,
   input  logic                         hold,
   input  logic                         accept,
   input  logic [tcw_pkg::KIND_W-1:0]   req_kind,
   input  logic [tcw_pkg::CHAR_W-1:0]   req_code,
   input  logic [CUR_W-1:0]             req_index,
   input  logic [tcw_pkg::ATTR_W-1:0]   attr,
   output tcw_pkg::status_type          status,
   output logic [tcw_pkg::CELL_W-1:0]   cell_data,
   output logic [CUR_W-1:0]             cursor_next,
   output logic                         scrolled
);

   import tcw_pkg::*;

   localparam int unsigned CELLS = COLUMNS * ROWS;
   localparam int unsigned AW    = $clog2(CELLS);

   localparam logic [CUR_W-1:0] COL_C      = CUR_W'(COLUMNS);
   localparam logic [CUR_W-1:0] CELLS_C    = CUR_W'(CELLS);
   localparam logic [CUR_W-1:0] LIM_COPY_C = CUR_W'(CELLS - COLUMNS - 1);
   localparam logic [CUR_W-1:0] LIM_END_C  = CUR_W'(CELLS - 1);

   logic              go;
   logic [CUR_W-1:0]  cursor_ff, cursor_in;
   logic [CUR_W-1:0]  line_ff, line_in;
   logic [CUR_W-1:0]  row_ff, row_in;
   logic [CUR_W-1:0]  addr_ff, addr_in;
   logic              scroll_ff, scroll_in;
   logic              pend_ff, pend_in;
   logic [AW-1:0]     wr_addr_ff;
   logic [KIND_W-1:0] kind_ff;
   logic [CHAR_W-1:0] code_ff;
   logic [CUR_W-1:0]  ridx_ff;

   logic [CUR_W-1:0]  cur_inc;
   logic [CUR_W-1:0]  row_nxt;
   logic [CUR_W-1:0]  copy_src;
   logic              range_ok;

   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [CELL_W-1:0] ram_wdata;
   logic              ram_re;
   logic [AW-1:0]     ram_raddr;
   logic [CELL_W-1:0] ram_rdata;

   assign go       = !hold;
   assign cur_inc  = cursor_ff + CUR_W'(1);
   assign row_nxt  = row_ff + COL_C;
   assign copy_src = addr_ff + COL_C;
   assign range_ok = (ridx_ff < CELLS_C);

   // cursor, row base and line start
   // row base tracks the start of the row holding the cursor, line start is always a row start
   always_comb begin
      cursor_in = cursor_ff;
      line_in   = line_ff;
      row_in    = row_ff;
      scroll_in = scroll_ff;
      if (accept) begin
         scroll_in = 1'b0;
      end
      if (go) begin
         case (cw.cur)
            CUR_INC: begin
               cursor_in = cur_inc;
               if (cur_inc == row_nxt) begin
                  row_in = row_nxt;
               end
            end
            CUR_NL: begin
               cursor_in = row_nxt;
               line_in   = row_nxt;
               row_in    = row_nxt;
            end
            CUR_CR: begin
               cursor_in = line_ff;
               row_in    = line_ff;
            end
            CUR_HOME: begin
               cursor_in = '0;
               line_in   = '0;
               row_in    = '0;
            end
            CUR_SCROLL: begin
               cursor_in = cursor_ff - COL_C;
               row_in    = row_ff - COL_C;
               line_in   = (line_ff >= COL_C) ? line_ff - COL_C : '0;
               scroll_in = 1'b1;
            end
            default: begin
               cursor_in = cursor_ff;
            end
         endcase
      end
   end

   // sweep address
   always_comb begin
      addr_in = addr_ff;
      if (go) begin
         case (cw.addr_op)
            ADDR_ZERO: addr_in = '0;
            ADDR_INC:  addr_in = addr_ff + CUR_W'(1);
            default:   addr_in = addr_ff;
         endcase
      end
   end

   // store ports: a copy write lands in the cycle after its read
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = addr_ff[AW-1:0];
      ram_wdata = '0;
      if (pend_ff) begin
         ram_we    = 1'b1;
         ram_waddr = wr_addr_ff;
         ram_wdata = ram_rdata;
      end else if (go) begin
         case (cw.wr)
            WR_ZERO: begin
               ram_we    = 1'b1;
               ram_waddr = addr_ff[AW-1:0];
               ram_wdata = '0;
            end
            WR_CHAR: begin
               ram_we    = 1'b1;
               ram_waddr = cursor_ff[AW-1:0];
               ram_wdata = {attr, code_ff};
            end
            default: begin
               ram_we = 1'b0;
            end
         endcase
      end
      ram_re    = go && (cw.copy || (cw.rd_item && range_ok));
      ram_raddr = cw.copy ? copy_src[AW-1:0] : ridx_ff[AW-1:0];
      pend_in   = go && cw.copy;
   end

   always_comb begin
      status.full      = (cursor_ff == CELLS_C);
      status.addr_last = (addr_ff == ((cw.lim == LIM_COPY) ? LIM_COPY_C : LIM_END_C));
      status.kind      = accept ? req_kind : kind_ff;
      status.code      = accept ? req_code : code_ff;
   end

   assign cell_data   = (cw.emit_rd && range_ok) ? ram_rdata : '0;
   assign cursor_next = cursor_in;
   assign scrolled    = scroll_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
         line_ff   <= '0;
         row_ff    <= '0;
         addr_ff   <= '0;
         scroll_ff <= 1'b0;
         pend_ff   <= 1'b0;
      end else begin
         cursor_ff <= cursor_in;
         line_ff   <= line_in;
         row_ff    <= row_in;
         addr_ff   <= addr_in;
         scroll_ff <= scroll_in;
         pend_ff   <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff <= addr_ff[AW-1:0];
      if (accept) begin
         kind_ff <= req_kind;
         code_ff <= req_code;
         ridx_ff <= req_index;
      end
   end

   tcw_screen_ram #(
      .DEPTH (CELLS),
      .AW    (AW),
      .DW    (CELL_W)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

endmodule

// File: hw/rtl/text_console_writer_unit.sv
// Text-mode console writer over a COLUMNS x ROWS screen of 16-bit cells (attribute in the
// high byte, character in the low byte) held in a single-port-write, single-port-read
// memory. Each req beat carries a kind on tuser (put, clear, read; the unused code only
// echoes the cursor) and returns exactly one rsp beat with the cell read, the linear cursor
// after the item and a scroll flag. A small microprogram in a constant control store walks
// the datapath one step per cycle, except while an emitting step waits on rsp
// back-pressure. A clear sweeps the whole store; a put that finds the cursor at the end
// of the screen first scrolls, which copies all rows but the first one cell per cycle
// through the memory's read and write ports and zeroes the last row. After reset the
// block clears the whole store with req_tready low; csr writes are taken throughout.
// The attribute register should only be written while no item is in flight.
module text_console_writer_unit #(
   parameter int unsigned COLUMNS = tcw_pkg::DEF_COLUMNS,
   parameter int unsigned ROWS    = tcw_pkg::DEF_ROWS,
   parameter int unsigned CUR_W   = $clog2(COLUMNS * ROWS + 1),
   parameter int unsigned REQ_W   = ((tcw_pkg::CHAR_W + CUR_W + 7) / 8) * 8,
   parameter int unsigned RSP_W   = ((tcw_pkg::CELL_W + CUR_W + 1 + 7) / 8) * 8
) (
   input  logic                       clock,
   input  logic                       reset,

   // attribute register
   input  logic                       csr_write_enable,
   input  logic [tcw_pkg::ATTR_W-1:0] csr_write_data,

   // item channel
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [REQ_W-1:0]           req_tdata,   // char_code, read_index, zero fill
   input  logic [tcw_pkg::KIND_W-1:0] req_tuser,   // kind

   // result channel
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [RSP_W-1:0]           rsp_tdata    // cell_data, cursor_position, scrolled, zero fill
);

   import tcw_pkg::*;

   localparam int unsigned CELLS = COLUMNS * ROWS;

   ctrl_word_type cw;
   status_type    status;

   logic              hold;
   logic              load;
   logic              accept;

   logic [ATTR_W-1:0] attr_ff;

   // output register, parts the sequencer from the rsp side
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0] rsp_cell_ff;
   logic [CUR_W-1:0]  rsp_cursor_ff;
   logic              rsp_scroll_ff;

   logic [CELL_W-1:0] dp_cell;
   logic [CUR_W-1:0]  dp_cursor;
   logic              dp_scrolled;

   // an emitting step waits while the previous beat is still held
   assign hold   = cw.emit && rsp_valid_ff && !rsp_tready;
   assign load   = cw.emit && !hold;
   assign accept = req_tvalid && req_tready;

   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff      <= ATTR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            attr_ff <= csr_write_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_cell_ff   <= dp_cell;
         rsp_cursor_ff <= dp_cursor;
         rsp_scroll_ff <= dp_scrolled;
      end
   end

   // pack result fields from bit zero up
   always_comb begin
      rsp_tdata                        = '0;
      rsp_tdata[CELL_W-1:0]            = rsp_cell_ff;
      rsp_tdata[CELL_W +: CUR_W]       = rsp_cursor_ff;
      rsp_tdata[CELL_W + CUR_W]        = rsp_scroll_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;

   // microprogram control
   tcw_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .hold      (hold),
      .req_valid (req_tvalid),
      .status    (status),
      .cw        (cw),
      .req_ready (req_tready)
   );

   // cursor registers, sweep counter and screen store
   tcw_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS),
      .CUR_W   (CUR_W)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cw          (cw),
      .hold        (hold),
      .accept      (accept),
      .req_kind    (req_tuser),
      .req_code    (req_tdata[CHAR_W-1:0]),
      .req_index   (req_tdata[CHAR_W +: CUR_W]),
      .attr        (attr_ff),
      .status      (status),
      .cell_data   (dp_cell),
      .cursor_next (dp_cursor),
      .scrolled    (dp_scrolled)
   );

   // the clearing pass keeps the item channel closed right after reset
   assert property (@(posedge clock) disable iff (reset) $past(reset) |-> !req_tready)
      else $error("item taken during the clearing pass");

   // the reported cursor never passes the end of the screen
   assert property (@(posedge clock) disable iff (reset)
                    rsp_tvalid |-> (rsp_tdata[CELL_W +: CUR_W] <= CUR_W'(CELLS)))
      else $error("cursor beyond screen end");

   // the accept step never waits on the output register
   assert property (@(posedge clock) disable iff (reset) req_tready |-> !hold)
      else $error("accept step stalled by output register");

endmodule

// File: sim/tb_text_console_writer_unit.sv
`timescale 1ns / 1ps

module tb_text_console_writer_unit;
   import tcw_pkg::*;

   // screen geometry at the block's defaults
   localparam int unsigned COLS         = DEF_COLUMNS;
   localparam int unsigned SCREEN_ROWS  = DEF_ROWS;
   localparam int unsigned SCREEN_CELLS = COLS * SCREEN_ROWS;
   localparam int unsigned CUR_W        = $clog2(SCREEN_CELLS + 1);
   localparam int unsigned REQ_W        = ((CHAR_W + CUR_W + 7) / 8) * 8;
   localparam int unsigned RSP_W        = ((CELL_W + CUR_W + 1 + 7) / 8) * 8;

   // kind code with no operation behind it
   localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

   // rsp beat layout, lowest bit first
   localparam int unsigned CUR_LSB  = CELL_W;
   localparam int unsigned SCR_BIT  = CELL_W + CUR_W;
   localparam int unsigned FILL_LSB = CELL_W + CUR_W + 1;

   // no handshake for this long means the block hung; a clear or a scroll
   // walks the whole store and the receiver may hold off
   localparam int unsigned QUIET_LIMIT  = 25000;
   localparam int unsigned MAX_GAP      = 18;
   localparam int unsigned RANDOM_ITEMS = 780;
   localparam int unsigned REPORT_MAX   = 30;

   typedef struct packed {
      logic [CELL_W-1:0] cell_value;
      logic [CUR_W-1:0]  cursor;
      logic              scrolled;
   } console_reply_t;

   logic              clock;
   logic              reset;
   logic              csr_write_enable;
   logic [ATTR_W-1:0] csr_write_data;
   logic              req_tvalid;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata;   // char_code, read_index, zero fill
   logic [KIND_W-1:0] req_tuser;   // kind
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [RSP_W-1:0]  rsp_tdata;   // cell_data, cursor_position, scrolled, zero fill

   // shadow of the console: screen cells, cursor, start of current line, attribute
   logic [CELL_W-1:0] screen_model [SCREEN_CELLS];
   int unsigned       cursor_model;
   int unsigned       line_start_model;
   logic [ATTR_W-1:0] attr_model;

   // replies predicted for accepted beats, oldest first
   console_reply_t    awaited_replies [$];

   // idling controls for both sides
   bit                req_idle_on;
   bit                rsp_idle_on;
   bit                req_offering;
   int unsigned       rsp_gap_left;
   int unsigned       rsp_hold_left;
   int unsigned       quiet_cycles;

   // bookkeeping for the summary
   int unsigned       error_count;
   int unsigned       checked_count;
   int unsigned       put_count;
   int unsigned       clear_count;
   int unsigned       read_count;
   int unsigned       unused_count;
   int unsigned       scroll_count;
   int unsigned       attr_writes;

   text_console_writer_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata)
   );

   // 12 ns clock, first rising edge at 6 ns
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // every input known from time zero
   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      req_tuser        = KIND_PUT;
      rsp_tready       = 1'b0;
   end

   // one line per mismatch, printing stops after a while but counting does not
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (error_count < REPORT_MAX) begin
         $display("%0t mismatch on beat %0d: %s got %0h expected %0h",
                  $time, checked_count, what, got, want);
      end
      error_count++;
   endtask

   // advance the shadow console by one item and return the reply it gives
   function automatic console_reply_t apply_console_item(input logic [KIND_W-1:0] kind,
                                                         input logic [CHAR_W-1:0] code,
                                                         input logic [CUR_W-1:0]  cell_index);
      console_reply_t reply;
      int unsigned    i;
      reply = '0;
      case (kind)
         KIND_PUT: begin
            // cursor parked past the last cell: move every row up, blank the last
            if (cursor_model >= SCREEN_CELLS) begin
               for (i = 0; i < SCREEN_CELLS - COLS; i++) begin
                  screen_model[i] = screen_model[i + COLS];
               end
               for (i = SCREEN_CELLS - COLS; i < SCREEN_CELLS; i++) begin
                  screen_model[i] = '0;
               end
               cursor_model -= COLS;
               // line start above the top row pins at zero
               line_start_model = (line_start_model >= COLS) ? line_start_model - COLS : 0;
               reply.scrolled = 1'b1;
            end
            if (code == CHAR_NEWLINE) begin
               cursor_model     = (cursor_model / COLS + 1) * COLS;
               line_start_model = cursor_model;
            end else if (code == CHAR_RETURN) begin
               cursor_model = line_start_model;
            end else begin
               if (cursor_model < SCREEN_CELLS) begin
                  screen_model[cursor_model] = {attr_model, code};
               end
               cursor_model++;
            end
         end
         KIND_CLEAR: begin
            for (i = 0; i < SCREEN_CELLS; i++) begin
               screen_model[i] = '0;
            end
            cursor_model     = 0;
            line_start_model = 0;
         end
         KIND_READ: begin
            // indexes past the screen read as zero
            if (cell_index < SCREEN_CELLS) begin
               reply.cell_value = screen_model[cell_index];
            end
         end
         default: begin
         end
      endcase
      reply.cursor = cursor_model[CUR_W-1:0];
      return reply;
   endfunction

   // drop tvalid once, only if it is up
   task automatic release_input();
      if (req_offering) begin
         req_tvalid   <= 1'b0;
         req_offering = 1'b0;
      end
   endtask

   // offer one beat after a random gap, wait for it to be taken, then predict;
   // with no gap tvalid simply stays high into the next beat
   task automatic send_item(input logic [KIND_W-1:0] kind, input logic [CHAR_W-1:0] code,
                            input logic [CUR_W-1:0] cell_index);
      int unsigned    gap;
      console_reply_t reply;
      gap = req_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         release_input();
         repeat (gap) @(posedge clock);
      end
      req_tvalid   <= 1'b1;
      req_tuser    <= kind;
      req_tdata    <= REQ_W'({cell_index, code});
      req_offering = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      reply = apply_console_item(kind, code, cell_index);
      awaited_replies.push_back(reply);
      case (kind)
         KIND_PUT:   put_count++;
         KIND_CLEAR: clear_count++;
         KIND_READ:  read_count++;
         default:    unused_count++;
      endcase
      if (reply.scrolled) scroll_count++;
   endtask

   // sender stops and waits until every reply is back
   task automatic wait_drained();
      release_input();
      while (awaited_replies.size() != 0) @(posedge clock);
   endtask

   // attribute writes only with the block idle
   task automatic set_attribute(input logic [ATTR_W-1:0] value);
      wait_drained();
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      attr_model = value;
      attr_writes++;
   endtask

   // read address: mostly on screen, often just behind the cursor, some past the end
   function automatic logic [CUR_W-1:0] pick_read_index();
      int unsigned r;
      int unsigned back;
      r    = $urandom_range(0, 9);
      back = $urandom_range(0, 40);
      if (r < 4) begin
         return CUR_W'($urandom_range(0, SCREEN_CELLS - 1));
      end else if (r < 5) begin
         return CUR_W'($urandom_range(SCREEN_CELLS, (1 << CUR_W) - 1));
      end else if (cursor_model > back) begin
         return CUR_W'(cursor_model - 1 - back);
      end
      return '0;
   endfunction

   task automatic send_random_item();
      int unsigned       r;
      logic [CHAR_W-1:0] code;
      r    = $urandom_range(0, 99);
      code = CHAR_W'($urandom_range(0, 255));
      if (r < 72) begin
         // text with a fair share of line controls
         case ($urandom_range(0, 19))
            0, 1:    code = CHAR_NEWLINE;
            2:       code = CHAR_RETURN;
            default: begin
            end
         endcase
         send_item(KIND_PUT, code, CUR_W'($urandom_range(0, (1 << CUR_W) - 1)));
      end else if (r < 92) begin
         send_item(KIND_READ, code, pick_read_index());
      end else if (r < 94) begin
         send_item(KIND_CLEAR, code, CUR_W'($urandom_range(0, (1 << CUR_W) - 1)));
      end else begin
         send_item(KIND_SPARE, code, CUR_W'($urandom_range(0, (1 << CUR_W) - 1)));
      end
   endtask

   // receiver: random gap before each beat, plus an optional long hold-off
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) begin
         rsp_gap_left = rsp_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_gap_left > 0) begin
         rsp_gap_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // compare every rsp beat against the oldest prediction
   always @(posedge clock) begin : rsp_monitor
      console_reply_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         checked_count++;
         if (awaited_replies.size() == 0) begin
            report_mismatch("unexpected beat", 32'(rsp_tdata), '0);
         end else begin
            want = awaited_replies.pop_front();
            if (rsp_tdata[CELL_W-1:0] !== want.cell_value) begin
               report_mismatch("cell_data", 32'(rsp_tdata[CELL_W-1:0]),
                               32'(want.cell_value));
            end
            if (rsp_tdata[CUR_LSB +: CUR_W] !== want.cursor) begin
               report_mismatch("cursor_position", 32'(rsp_tdata[CUR_LSB +: CUR_W]),
                               32'(want.cursor));
            end
            if (rsp_tdata[SCR_BIT] !== want.scrolled) begin
               report_mismatch("scrolled", 32'(rsp_tdata[SCR_BIT]), 32'(want.scrolled));
            end
            if (rsp_tdata[RSP_W-1:FILL_LSB] !== '0) begin
               report_mismatch("zero fill", 32'(rsp_tdata[RSP_W-1:FILL_LSB]), '0);
            end
         end
      end
   end

   // hang detector: cycles in a row with no beat on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout after %0d quiet cycles", quiet_cycles);
         $display("text_console_writer_unit test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // empty screen reads, reads past the end, unused kind, reset attribute
   task automatic test_reset_state();
      send_item(KIND_READ, 8'h00, 11'd0);
      send_item(KIND_READ, 8'hff, CUR_W'(SCREEN_CELLS - 1));
      send_item(KIND_READ, 8'h00, CUR_W'(SCREEN_CELLS));
      send_item(KIND_READ, 8'h00, '1);
      send_item(KIND_SPARE, 8'hff, '1);
      send_item(KIND_PUT, 8'h00, '0);
      send_item(KIND_PUT, 8'hff, '1);
      send_item(KIND_PUT, 8'h41, '0);
      send_item(KIND_READ, 8'h00, 11'd0);
      send_item(KIND_READ, 8'h00, 11'd1);
      send_item(KIND_READ, 8'h00, 11'd2);
   endtask

   // carriage return, newline, blank row after a filled row, attribute extremes
   task automatic test_line_control();
      send_item(KIND_PUT, CHAR_RETURN, '0);
      send_item(KIND_PUT, 8'h63, '0);
      send_item(KIND_PUT, CHAR_NEWLINE, '0);
      send_item(KIND_PUT, CHAR_NEWLINE, '0);
      set_attribute(8'h00);
      send_item(KIND_PUT, 8'h78, '0);
      set_attribute(8'hff);
      send_item(KIND_PUT, 8'h79, '0);
      send_item(KIND_PUT, CHAR_RETURN, '0);
      send_item(KIND_READ, 8'h00, CUR_W'(2 * COLS));
      send_item(KIND_READ, 8'h00, CUR_W'(2 * COLS + 1));
      send_item(KIND_CLEAR, 8'h00, '0);
      send_item(KIND_READ, 8'h00, CUR_W'(2 * COLS + 1));
   endtask

   // newlines down to the end of the screen, then puts that scroll
   task automatic test_scroll();
      repeat (SCREEN_ROWS) send_item(KIND_PUT, CHAR_NEWLINE, '0);
      send_item(KIND_PUT, 8'h71, '0);
      send_item(KIND_PUT, CHAR_NEWLINE, '0);
      send_item(KIND_PUT, CHAR_RETURN, '0);
      send_item(KIND_PUT, CHAR_NEWLINE, '0);
      send_item(KIND_PUT, CHAR_NEWLINE, '0);
      send_item(KIND_READ, 8'h00, CUR_W'(SCREEN_CELLS - 2 * COLS));
      send_item(KIND_READ, 8'h00, CUR_W'(SCREEN_CELLS - COLS));
   endtask

   // a line started two rows above the bottom that wraps past the end, so the
   // scroll lands mid-line and moves the line start up; no idling on either side
   task automatic test_long_line();
      set_attribute(8'ha5);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      send_item(KIND_CLEAR, 8'h00, '0);
      repeat (SCREEN_ROWS - 2) send_item(KIND_PUT, CHAR_NEWLINE, '0);
      repeat (2 * COLS + 5) send_item(KIND_PUT, CHAR_W'($urandom_range(32, 126)), '0);
      send_item(KIND_PUT, 8'h5a, '0);
      send_item(KIND_PUT, CHAR_RETURN, '0);
      send_item(KIND_READ, 8'h00, CUR_W'(SCREEN_CELLS - COLS));
      send_item(KIND_READ, 8'h00, CUR_W'($urandom_range(0, SCREEN_CELLS - 1)));
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   // receiver holds off while the sender keeps offering, then sender drains
   task automatic test_backpressure();
      wait_drained();
      req_idle_on   = 1'b0;
      rsp_hold_left = 300;
      repeat (16) send_random_item();
      req_idle_on = 1'b1;
      wait_drained();
   endtask

   // random segments, each with its own idling mix, attribute changed now and then
   task automatic test_random_traffic();
      int unsigned sent;
      int unsigned seg_len;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         seg_len     = $urandom_range(20, 80);
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 4) == 0) set_attribute(ATTR_W'($urandom_range(0, 255)));
         repeat (seg_len) send_random_item();
         sent += seg_len;
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   initial begin
      for (int unsigned i = 0; i < SCREEN_CELLS; i++) screen_model[i] = '0;
      cursor_model     = 0;
      line_start_model = 0;
      attr_model       = ATTR_RESET;
      req_idle_on      = 1'b1;
      rsp_idle_on      = 1'b1;
      req_offering     = 1'b0;
      rsp_gap_left     = 0;
      rsp_hold_left    = 0;
      quiet_cycles     = 0;
      error_count      = 0;
      checked_count    = 0;
      put_count        = 0;
      clear_count      = 0;
      read_count       = 0;
      unused_count     = 0;
      scroll_count     = 0;
      attr_writes      = 0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_line_control();
      test_scroll();
      test_long_line();
      test_backpressure();
      test_random_traffic();

      // tail: nothing owed, then wait for stray beats
      wait_drained();
      repeat (20) @(posedge clock);

      $display("covered %0d puts (%0d scrolls), %0d clears, %0d reads, %0d unused-kind beats",
               put_count, scroll_count, clear_count, read_count, unused_count);
      $display("%0d attribute writes, %0d result beats checked, %0d mismatches",
               attr_writes, checked_count, error_count);
      if (error_count == 0) begin
         $display("text_console_writer_unit test passed");
      end else begin
         $display("text_console_writer_unit test failed");
      end
      $finish;
   end

endmodule

// File: text_console_writer_unit.f
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_screen_ram.sv
hw/rtl/tcw_sequencer.sv
hw/rtl/tcw_datapath.sv
hw/rtl/text_console_writer_unit.sv
sim/tb_text_console_writer_unit.sv
